// ----- sv/cbm_pkg.sv -----
package cbm_pkg;

    localparam int DATA_W     = 8;
    localparam int NUM_CHR    = 8;
    localparam int NUM_LANES  = NUM_CHR + 1;
    localparam int STEP_W     = $clog2(DATA_W);
    localparam int CNT_W      = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [3:0] REG_CHR_FIRST = 4'd0;
    localparam logic [3:0] REG_CHR_LAST  = 4'd7;
    localparam logic [3:0] REG_OUTER_PRG = 4'd8;
    localparam logic [3:0] REG_LATCH_LO  = 4'd9;
    localparam logic [3:0] REG_LATCH_HI  = 4'd10;
    localparam logic [3:0] REG_IRQ_CTRL  = 4'd11;

    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_ctl_state;

    typedef struct packed {
        logic apply;
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // one restoring remainder step: shift in next dividend bit, subtract if it fits
    function automatic logic [DATA_W-1:0] mod_step(input logic [DATA_W-1:0] rem,
                                                   input logic              nbit,
                                                   input logic [DATA_W-1:0] div);
        logic [DATA_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[DATA_W-1:0];
    endfunction

endpackage

// ----- sv/cbm_ctrl.sv -----
module cbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  cbm_pkg::t_dp_sts  i_sts,
    output cbm_pkg::t_dp_cmd  o_cmd
);
    import cbm_pkg::*;

    t_ctl_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.apply, o_cmd.load, o_cmd.step, o_cmd.emit}))
        else $error("controller issued more than one command");

    a_full_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIV) && (r_step == '0))
        else $error("division did not start from step zero");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_s_tready)
        else $error("not ready after result handed over");

endmodule

// ----- sv/cbm_dpath.sv -----
module cbm_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cbm_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                               i_op,
    input  logic [cbm_pkg::IN_DATA_W-1:0]      i_item,
    input  cbm_pkg::t_dp_cmd                   i_cmd,
    output cbm_pkg::t_dp_sts                   o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cbm_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import cbm_pkg::*;

    logic [DATA_W-1:0] r_prg_cnt, r_chr_cnt;
    logic [DATA_W-1:0] r_chr [NUM_CHR];
    logic [6:0]        r_prg_sel;
    logic              r_outer;
    logic              r_count_en;
    logic [CNT_W-1:0]  r_counter;
    logic [CNT_W-1:0]  r_latch;
    logic              r_raise, r_ack;
    logic [DATA_W-1:0] r_num [NUM_LANES];
    logic [DATA_W-1:0] r_rem [NUM_LANES];
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic [3:0]        in_reg;
    logic [DATA_W-1:0] in_data;
    logic [CNT_W-1:0]  in_cycles;
    logic [DATA_W-1:0] prg_last;
    logic [DATA_W-1:0] prg_high;
    logic [DATA_W-1:0] lowsum;
    logic [OUT_DATA_W-1:0] n_out;

    assign in_reg    = i_item[3:0];
    assign in_data   = i_item[11:4];
    assign in_cycles = i_item[27:12];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_cnt <= 8'd16;
            r_chr_cnt <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRG_COUNT: r_prg_cnt <= i_cfg_data;
                CFG_CHR_COUNT: r_chr_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mapper state update on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHR; i++) begin
                r_chr[i] <= '0;
            end
            r_prg_sel  <= '0;
            r_outer    <= 1'b0;
            r_count_en <= 1'b0;
            r_counter  <= '0;
            r_latch    <= '0;
            r_raise    <= 1'b0;
            r_ack      <= 1'b0;
        end else if (i_cmd.apply) begin
            r_raise <= 1'b0;
            r_ack   <= 1'b0;
            if (i_op == OP_WRITE) begin
                case (in_reg) inside
                    [REG_CHR_FIRST:REG_CHR_LAST]: r_chr[in_reg[2:0]] <= in_data;
                    REG_OUTER_PRG: begin
                        r_outer   <= in_data[0];
                        r_prg_sel <= in_data[7:1];
                    end
                    REG_LATCH_LO: r_latch[7:0]  <= in_data;
                    REG_LATCH_HI: r_latch[15:8] <= in_data;
                    REG_IRQ_CTRL: begin
                        r_count_en <= in_data[0];
                        r_counter  <= r_latch;
                        r_ack      <= 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_count_en) begin
                if (r_counter <= in_cycles) begin
                    r_counter  <= '0;
                    r_count_en <= 1'b0;
                    r_raise    <= 1'b1;
                end else begin
                    r_counter <= r_counter - in_cycles;
                end
            end
        end
    end

    assign lowsum = {4'd0, r_outer, 3'd0} + {1'b0, r_prg_sel};

    // remainder lanes: lane 0 is the prg window, lanes 1..8 the chr slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num[0] <= lowsum;
            r_rem[0] <= '0;
            for (int i = 0; i < NUM_CHR; i++) begin
                r_num[i+1] <= r_chr[i];
                r_rem[i+1] <= '0;
            end
        end else if (i_cmd.step) begin
            r_num[0] <= {r_num[0][DATA_W-2:0], 1'b0};
            r_rem[0] <= mod_step(r_rem[0], r_num[0][DATA_W-1], r_prg_cnt);
            for (int i = 1; i < NUM_LANES; i++) begin
                r_num[i] <= {r_num[i][DATA_W-2:0], 1'b0};
                r_rem[i] <= mod_step(r_rem[i], r_num[i][DATA_W-1], r_chr_cnt);
            end
        end
    end

    assign prg_last = r_prg_cnt - 8'd1;
    assign prg_high = {5'd0, r_outer, 2'd0} + {1'b0, prg_last[7:1]};

    always_comb begin
        n_out        = '0;
        n_out[6:0]   = r_rem[0][7:1];
        n_out[14:7]  = prg_high;
        for (int i = 0; i < NUM_CHR; i++) begin
            n_out[15 + i*DATA_W +: DATA_W] = (r_chr_cnt == '0) ? '0 : r_rem[i+1];
        end
        n_out[79]    = r_raise;
        n_out[80]    = r_ack;
    end

    // output register: holds a finished word while the next one is worked on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    a_irq_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out[79] && r_out[80]))
        else $error("raise and acknowledge in the same word");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted word not presented");

    a_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && i_op == OP_TICK && r_count_en && r_counter <= in_cycles)
        |=> (r_counter == '0) && !r_count_en && r_raise)
        else $error("counter expiry not handled");

endmodule

// ----- sv/cartridge_bank_mapper_irq.sv -----
// Cartridge bank mapper with a cycle-count interrupt. Each input word is either a
// register write or a CPU tick; each yields one output word with the two 16KB PRG
// banks, the eight 1KB CHR banks and the irq raise / acknowledge flags. An accepted
// word is handled in order: state update, load, reduction of the bank numbers modulo
// the bank counts in nine bit-serial remainder lanes, hand-over; the next word is
// taken while the previous result waits in the output register. The user must write
// bank counts on the cfg port only while no word is in flight; this is not enforced.
module cartridge_bank_mapper_irq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cbm_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] reg_index, [11:4] write_data, [27:12] tick_cycles, rest zero
    input  logic [cbm_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [6:0] prg_low_bank, [14:7] prg_high_bank, [22:15]..[78:71] chr_bank_zero..seven,
    // [79] irq_raise, [80] irq_acknowledge, rest zero
    output logic [cbm_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import cbm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    cbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_tuser),
        .i_item      (s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata)
    );

endmodule
